// ===== src/kmp_stream_matcher_assert.svh =====
// Assertion macros shared by the matcher RTL.
// Each macro expects clk and rst_n in the including scope.
`ifndef KMP_STREAM_MATCHER_ASSERT_SVH
`define KMP_STREAM_MATCHER_ASSERT_SVH

// Same-cycle implication
`define KMP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KMP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kmp_pkg.sv =====
package kmp_pkg;

  // Pattern store geometry
  localparam int MAX_PATTERN = 32;
  localparam int ADDR_W      = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 16;
  localparam int START_W = 16;

  // Input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PATTERN = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  // One result item
  typedef struct packed {
    logic               matched;
    logic [START_W-1:0] match_start;
    logic               pattern_overflow;
  } res_t;

endpackage

// ===== src/kmp_ram.sv =====
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/kmp_result_buf.sv =====
`include "kmp_stream_matcher_assert.svh"

module kmp_result_buf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  kmp_pkg::res_t               push_res,
  output logic                        space,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_matched,
  output logic [kmp_pkg::START_W-1:0] out_match_start,
  output logic                        out_pattern_overflow
);

  import kmp_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;
  assign space    = !skid_valid_r;

  // Output register with one skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        out_valid_nxt  = 1'b1;
        skid_res_nxt   = push_res;
        skid_valid_nxt = push;
      end else begin
        out_res_nxt   = push_res;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_res_nxt   = push_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_res_r.matched;
  assign out_match_start      = out_res_r.match_start;
  assign out_pattern_overflow = out_res_r.pattern_overflow;

  `KMP_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r, "skid holds a result ahead of output")
  `KMP_ASSERT_NXT(a_stall_to_skid, push && out_valid_r && !out_ready, skid_valid_r,
                  "stalled push not kept in skid")
  `KMP_ASSERT_NXT(a_out_hold, out_valid_r && !out_ready, out_valid_r && $stable(out_res_r),
                  "stalled result changed or dropped")

endmodule

// ===== src/kmp_stream_matcher.sv =====
// Channel  | Ports                                       | Direction
// ---------+---------------------------------------------+----------
// input    | in_valid, in_ready, in_kind, in_data_byte   | in
// result   | out_valid, out_ready, out_matched,          | out
//          | out_match_start, out_pattern_overflow       |
//
// Text bytes and pattern bytes into a non-empty store go through a lookup: a read,
// then a compare, with one read of both memories per failure-table fallback step.
// Restart, clear, empty-pattern text, first and dropped pattern bytes need no lookup.
// Reset (rst_n, synchronous, active low) clears lengths, position and handshake
// state; the memories are not cleared.
// in_ready is low during a lookup and while the skid entry holds a result.
`include "kmp_stream_matcher_assert.svh"

module kmp_stream_matcher (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kmp_pkg::KIND_W-1:0]  in_kind,
  input  logic [kmp_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_matched,
  output logic [kmp_pkg::START_W-1:0] out_match_start,
  output logic                        out_pattern_overflow
);

  import kmp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [ADDR_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]    plen_r, plen_nxt;
  logic [ADDR_W-1:0]   pbl_r, pbl_nxt;
  logic [LEN_W-1:0]    cml_r, cml_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;

  logic                accept;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   fail_rd_addr;
  logic [BYTE_W-1:0]   pat_q;
  logic [ADDR_W-1:0]   fail_q;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [BYTE_W-1:0]   wr_pat;
  logic [ADDR_W-1:0]   wr_fail;
  logic                push;
  res_t                push_res;
  logic                buf_space;
  logic                ext;
  logic [LEN_W-1:0]    new_len;
  logic [ADDR_W-1:0]   j_start;

  assign in_ready     = (state_r == S_IDLE) && buf_space;
  assign accept       = in_valid && in_ready;
  // failure value of a prefix of length len sits at entry len-1
  assign fail_rd_addr = rd_addr - ADDR_W'(1);

  // Pattern characters and failure table
  kmp_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_pat),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (pat_q)
  );

  kmp_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_PATTERN)) u_fail_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_fail),
    .rd_en   (rd_en),
    .rd_addr (fail_rd_addr),
    .rd_data (fail_q)
  );

  // Sequencer: issue read, compare, fall back or commit.
  // Writes happen on a commit or on the first pattern byte, never together with
  // a read, and the next read starts after a new transfer, so accesses never overlap.
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    len_nxt   = len_r;
    plen_nxt  = plen_r;
    pbl_nxt   = pbl_r;
    cml_nxt   = cml_r;
    pos_nxt   = pos_r;
    rd_en     = 1'b0;
    rd_addr   = len_r;
    wr_en     = 1'b0;
    wr_addr   = plen_r[ADDR_W-1:0];
    wr_pat    = byte_r;
    wr_fail   = '0;
    push      = 1'b0;
    push_res  = '0;
    ext       = (pat_q == byte_r) && (LEN_W'(len_r) < plen_r);
    new_len   = LEN_W'(len_r) + LEN_W'(ext);
    j_start   = (cml_r >= plen_r) ? '0 : cml_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt = kind_t'(in_kind);
          byte_nxt = in_data_byte;
          case (kind_t'(in_kind))
            KIND_PATTERN: begin
              if (plen_r == LEN_W'(MAX_PATTERN)) begin
                push                      = 1'b1;
                push_res.pattern_overflow = 1'b1;
              end else if (plen_r == '0) begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                wr_pat   = in_data_byte;
                wr_fail  = '0;
                pbl_nxt  = '0;
                plen_nxt = LEN_W'(1);
                push     = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = pbl_r;
                len_nxt   = pbl_r;
                state_nxt = S_LOOK;
              end
            end
            KIND_TEXT: begin
              if (plen_r == '0) begin
                pos_nxt = pos_r + POS_W'(1);
                push    = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = j_start;
                len_nxt   = j_start;
                state_nxt = S_LOOK;
              end
            end
            KIND_RESTART: begin
              cml_nxt = '0;
              pos_nxt = '0;
              push    = 1'b1;
            end
            KIND_CLEAR: begin
              plen_nxt = '0;
              pbl_nxt  = '0;
              cml_nxt  = '0;
              push     = 1'b1;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      S_LOOK: begin
        if ((len_r != '0) && (pat_q != byte_r)) begin
          // mismatch: fall back one table step
          len_nxt = fail_q;
          rd_en   = 1'b1;
          rd_addr = fail_q;
        end else begin
          state_nxt = S_IDLE;
          push      = 1'b1;
          if (kind_r == KIND_PATTERN) begin
            wr_en    = 1'b1;
            wr_addr  = plen_r[ADDR_W-1:0];
            wr_pat   = byte_r;
            wr_fail  = new_len[ADDR_W-1:0];
            pbl_nxt  = new_len[ADDR_W-1:0];
            plen_nxt = plen_r + LEN_W'(1);
          end else begin
            pos_nxt = pos_r + POS_W'(1);
            if (new_len == plen_r) begin
              // full occurrence; continue from the last entry's failure value
              push_res.matched     = 1'b1;
              push_res.match_start = START_W'(pos_r - POS_W'(plen_r - LEN_W'(1)));
              cml_nxt              = LEN_W'(pbl_r);
            end else begin
              cml_nxt = new_len;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      plen_r  <= '0;
      pbl_r   <= '0;
      cml_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      plen_r  <= plen_nxt;
      pbl_r   <= pbl_nxt;
      cml_r   <= cml_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    len_r  <= len_nxt;
  end

  kmp_result_buf u_result_buf (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .push_res             (push_res),
    .space                (buf_space),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_matched          (out_matched),
    .out_match_start      (out_match_start),
    .out_pattern_overflow (out_pattern_overflow)
  );

  `KMP_ASSERT_IMP(a_wr_no_read, wr_en, !rd_en, "memory write and read in the same cycle")
  `KMP_ASSERT_IMP(a_push_has_space, push && (state_r == S_LOOK), buf_space,
                  "result pushed with skid occupied")
  `KMP_ASSERT_IMP(a_plen_cap, 1'b1, plen_r <= LEN_W'(MAX_PATTERN), "pattern length above capacity")
  `KMP_ASSERT_IMP(a_pbl_below_plen, plen_r != '0, LEN_W'(pbl_r) < plen_r,
                  "prefix length not below pattern length")
  `KMP_ASSERT_NXT(a_fallback_stays, (state_r == S_LOOK) && !push, state_r == S_LOOK,
                  "fallback step left the lookup loop")

endmodule

// ===== test/kmp_stream_matcher_tb.sv =====
module kmp_stream_matcher_tb;
  import kmp_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int IDLE_LIMIT = 3000;
  localparam int MAX_SHOWN  = 10;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind = KIND_TEXT;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_matched;
  logic [START_W-1:0]  out_match_start;
  logic                out_pattern_overflow;

  kmp_stream_matcher dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_matched          (out_matched),
    .out_match_start      (out_match_start),
    .out_pattern_overflow (out_pattern_overflow)
  );

  // Shadow matcher state
  logic [BYTE_W-1:0] shadow_pattern [MAX_PATTERN];
  logic [LEN_W-1:0]  shadow_failure [MAX_PATTERN];
  int                shadow_pat_len;
  int                shadow_build_len;
  int                shadow_match_len;
  logic [POS_W-1:0]  shadow_text_pos;

  res_t              pending_results [$];
  int                mismatch_count;
  int                idle_cycles;

  // Traffic shaping knobs
  int                send_idle_pct;
  int                recv_stall_pct;
  int                recv_hold_left;
  logic [BYTE_W-1:0] alphabet [3];

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Expected result of one item; updates the shadow state
  function automatic res_t match_predict(kind_t k, logic [BYTE_W-1:0] b);
    res_t r;
    int   len;
    r = '0;
    case (k)
      KIND_PATTERN: begin
        if (shadow_pat_len >= MAX_PATTERN) begin
          r.pattern_overflow = 1'b1;
        end else begin
          shadow_pattern[shadow_pat_len] = b;
          if (shadow_pat_len == 0) begin
            shadow_build_len = 0;
          end else begin
            len = shadow_build_len;
            while (len > 0 && shadow_pattern[len] != b) len = shadow_failure[len-1];
            if (shadow_pattern[len] == b) len++;
            shadow_build_len = len;
          end
          shadow_failure[shadow_pat_len] = LEN_W'(shadow_build_len);
          shadow_pat_len++;
        end
      end
      KIND_TEXT: begin
        if (shadow_pat_len > 0) begin
          len = shadow_match_len;
          if (len >= shadow_pat_len) len = 0;
          while (len > 0 && len < MAX_PATTERN && shadow_pattern[len] != b)
            len = shadow_failure[len-1];
          if (len < shadow_pat_len && len < MAX_PATTERN && shadow_pattern[len] == b) len++;
          if (len == shadow_pat_len) begin
            r.matched     = 1'b1;
            r.match_start = START_W'(shadow_text_pos - POS_W'(shadow_pat_len - 1));
            len           = shadow_failure[len-1];
          end
          shadow_match_len = len;
        end
        shadow_text_pos = shadow_text_pos + POS_W'(1);
      end
      KIND_RESTART: begin
        shadow_match_len = 0;
        shadow_text_pos  = '0;
      end
      default: begin
        shadow_pat_len   = 0;
        shadow_build_len = 0;
        shadow_match_len = 0;
      end
    endcase
    return r;
  endfunction

  // Offer one item, starting and ending on a falling edge
  task automatic send_item(kind_t k, logic [BYTE_W-1:0] b);
    res_t expected;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    expected        = match_predict(k, b);
    pending_results = {pending_results, expected};
    @(negedge clk);
  endtask

  // Sender pauses until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Mostly the first two alphabet symbols, so that matches are frequent
  function automatic logic [BYTE_W-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 80) return alphabet[$urandom_range(1)];
    if (r < 95) return alphabet[2];
    return BYTE_W'($urandom);
  endfunction

  // Receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      out_ready <= 1'b0;
      recv_hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected result: matched=%0b start=%0d overflow=%0b",
                   out_matched, out_match_start, out_pattern_overflow);
      end else begin
        want = pending_results.pop_front();
        if (out_matched !== want.matched || out_match_start !== want.match_start ||
            out_pattern_overflow !== want.pattern_overflow) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("mismatch: expected matched=%0b start=%0d overflow=%0b, got %0b %0d %0b",
                     want.matched, want.match_start, want.pattern_overflow,
                     out_matched, out_match_start, out_pattern_overflow);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Empty pattern never matches, position still moves; then a one-byte pattern
  task automatic test_empty_pattern();
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_PATTERN, 8'hFF);
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_RESTART, 8'hFF);
  endtask

  // Extreme bytes and overlapping occurrences, then restart and clear
  task automatic test_overlap_extremes();
    send_item(KIND_CLEAR, 8'h00);
    send_item(KIND_PATTERN, 8'h00);
    send_item(KIND_PATTERN, 8'hFF);
    send_item(KIND_PATTERN, 8'h00);
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_RESTART, 8'h55);
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_CLEAR, 8'hAA);
    send_item(KIND_TEXT, 8'h00);
  endtask

  // Pattern grown while a partial match is in progress
  task automatic test_growth_mid_text();
    send_item(KIND_PATTERN, 8'h41);
    send_item(KIND_PATTERN, 8'h42);
    send_item(KIND_TEXT, 8'h41);
    send_item(KIND_PATTERN, 8'h43);
    send_item(KIND_TEXT, 8'h42);
    send_item(KIND_TEXT, 8'h43);
  endtask

  // Fill the pattern store, then overflow it
  task automatic test_full_store();
    alphabet[0] = 8'h01;
    alphabet[1] = 8'h02;
    alphabet[2] = 8'h03;
    send_item(KIND_CLEAR, 8'h00);
    for (int i = 0; i < MAX_PATTERN + 3; i++) send_item(KIND_PATTERN, pick_char());
    for (int i = 0; i < 80; i++) send_item(KIND_TEXT, pick_char());
    send_item(KIND_CLEAR, 8'h00);
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    alphabet[0] = 8'h10;
    alphabet[1] = 8'h20;
    alphabet[2] = 8'h30;
    send_item(KIND_CLEAR, 8'h00);
    send_item(KIND_PATTERN, 8'h10);
    send_item(KIND_PATTERN, 8'h20);
    recv_hold_left = 300;
    for (int i = 0; i < 40; i++) send_item(KIND_TEXT, pick_char());
    drain_results();
  endtask

  // Random pattern/text sequences with some noise
  task automatic test_random(int n_items);
    int sent;
    int plen;
    int tlen;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_item(kind_t'($urandom_range(3)), BYTE_W'($urandom));
        sent++;
      end else begin
        for (int i = 0; i < 3; i++) alphabet[i] = BYTE_W'($urandom);
        if ($urandom_range(1) == 1) begin
          send_item(KIND_CLEAR, BYTE_W'($urandom));
          sent++;
        end
        if ($urandom_range(19) == 0) plen = $urandom_range(MAX_PATTERN + 2, 8);
        else plen = $urandom_range(6, 1);
        for (int i = 0; i < plen; i++) send_item(KIND_PATTERN, pick_char());
        tlen = $urandom_range(40, 10);
        for (int i = 0; i < tlen; i++) begin
          r = $urandom_range(99);
          if (r < 3) send_item(KIND_RESTART, BYTE_W'($urandom));
          else if (r < 6) send_item(KIND_PATTERN, pick_char());
          else send_item(KIND_TEXT, pick_char());
        end
        sent += plen + tlen;
      end
    end
  endtask

  initial begin
    shadow_pat_len   = 0;
    shadow_build_len = 0;
    shadow_match_len = 0;
    shadow_text_pos  = '0;
    mismatch_count   = 0;
    idle_cycles      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    recv_hold_left   = 0;
    for (int i = 0; i < 3; i++) alphabet[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_pattern();
    test_overlap_extremes();
    test_growth_mid_text();
    drain_results();
    test_full_store();
    drain_results();
    test_backpressure();

    // Idle phases: none, sender, receiver, both lightly
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      test_random(260);
      drain_results();
    end

    // Let any stray result show up
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
